### hw/rtl/sprite_y_sorted_table_defines.svh
// assertion macros for the y-sorted sprite table
`ifndef SPRITE_Y_SORTED_TABLE_DEFINES_SVH
`define SPRITE_Y_SORTED_TABLE_DEFINES_SVH
// property that must hold at every clock edge out of reset
`define SYS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("%m: lbl");
// implication checked in the next cycle
`define SYS_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error("%m: lbl");
`endif

### hw/rtl/sysort_pkg.sv
// package: types and constants for the y-sorted sprite table
package sysort_pkg;
    localparam int POOL_ENTRIES_DEF = 32;
    localparam int HW_SLOTS_DEF     = 8;
    localparam logic [7:0] START_POS = 8'hfe;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_SET_Y = 2'd1;
    localparam logic [1:0] OP_SET_X = 2'd2;
    localparam logic [1:0] OP_BAD   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_NOHNDL = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [4:0] handle;
        logic [7:0] y_position;
        logic [8:0] x_position;
        logic       double_size;
    } cmd_t;

    typedef struct packed {
        logic [4:0] entry_id;
        logic [4:0] order_position;
        logic [7:0] slot_mask;
        logic       high_x;
        logic [5:0] entry_count;
        logic [1:0] status;
    } result_t;

    // broadcast control from the sequencer to the cells
    typedef struct packed {
        logic load;      // write handle into the tail cell
        logic swap_dn;   // cells at a and a+1 exchange
        logic setx;      // write x in cell holding the handle
        logic sety;      // write y in cell holding the handle
    } cell_ctl_t;
endpackage

### hw/rtl/sysort_cell.sv
// one position of the display order: handle, y, x and the double-size flag
module sysort_cell #(
    parameter int IDX = 0,
    parameter int AW  = 5,
    parameter int HDW = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sysort_pkg::cell_ctl_t ctl,
    input  logic [AW-1:0]         ptr,
    input  logic [HDW-1:0]        cmd_handle,
    input  logic [7:0]            cmd_y,
    input  logic [8:0]            cmd_x,
    input  logic                  cmd_dbl,
    // neighbor above (position IDX+1) and below (IDX-1)
    input  logic [HDW-1:0]        up_handle,
    input  logic [7:0]            up_y,
    input  logic [8:0]            up_x,
    input  logic                  up_dbl,
    input  logic [HDW-1:0]        dn_handle,
    input  logic [7:0]            dn_y,
    input  logic [8:0]            dn_x,
    input  logic                  dn_dbl,
    output logic [HDW-1:0]        handle,
    output logic [7:0]            y,
    output logic [8:0]            x,
    output logic                  dbl
);
    import sysort_pkg::*;

    logic [HDW-1:0] handle_reg;
    logic [7:0]     y_reg;
    logic [8:0]     x_reg;
    logic           dbl_reg;
    logic           here;
    logic           below;

    assign here  = (ptr == AW'(IDX));
    assign below = (ptr == AW'(IDX - 1)) && (IDX > 0);

    // payload moves: append, swap with neighbor, field writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            handle_reg <= '0;
            y_reg      <= '0;
            x_reg      <= '0;
            dbl_reg    <= 1'b0;
        end
        else if (ctl.load && here)
        begin
            handle_reg <= cmd_handle;
            y_reg      <= START_POS;
            x_reg      <= {1'b0, START_POS};
            dbl_reg    <= cmd_dbl;
        end
        else if (ctl.swap_dn && here)
        begin
            handle_reg <= up_handle;
            y_reg      <= up_y;
            x_reg      <= up_x;
            dbl_reg    <= up_dbl;
        end
        else if (ctl.swap_dn && below)
        begin
            handle_reg <= dn_handle;
            y_reg      <= dn_y;
            x_reg      <= dn_x;
            dbl_reg    <= dn_dbl;
        end
        else if (ctl.setx && here)
        begin
            x_reg <= cmd_x;
        end
        else if (ctl.sety && here)
        begin
            y_reg <= cmd_y;
        end
    end

    assign handle = handle_reg;
    assign y      = y_reg;
    assign x      = x_reg;
    assign dbl    = dbl_reg;
endmodule

### hw/rtl/sprite_y_sorted_table.sv
// top level: y-sorted sprite table, a chain of order cells and a sequencer
// Usage: a command transaction is taken when start is high and busy low.
// Allocate appends the next pool entry at the end of the order; set-x and
// set-y address an entry by handle. Each command yields one result on
// result with done high for exactly one cycle; the receiver cannot stall.
// The order lives in a chain of cells, one per position. Set-x and set-y
// first scan the chain one cell per cycle to find the handle, then set-y
// swaps the entry with one neighbor per cycle until order holds; when y
// is unchanged no swap is made. Allocate, unknown handles and a full pool
// go straight to the result without a scan.
// Busy stays high from acceptance until the result cycle ends; the next
// command may be taken the cycle after done.
// Reset clears the entry count, the sequencer and the cells; cell contents
// are meaningless until allocated and are never read before then.
module sprite_y_sorted_table #(
    parameter int POOL_ENTRIES = sysort_pkg::POOL_ENTRIES_DEF,
    parameter int HW_SLOTS     = sysort_pkg::HW_SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  sysort_pkg::cmd_t    cmd,
    output logic                busy,
    output logic                done,
    output sysort_pkg::result_t result
);
    import sysort_pkg::*;
    `include "sprite_y_sorted_table_defines.svh"

    localparam int AW  = $clog2(POOL_ENTRIES);
    localparam int CW  = $clog2(POOL_ENTRIES + 1);
    localparam int HDW = (AW > 5) ? AW : 5;
    localparam int KW  = (CW > 5) ? CW : 5;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FIND = 3'd1;
    localparam logic [2:0] S_UP   = 3'd2;
    localparam logic [2:0] S_DOWN = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]    state_reg, state_next;
    cmd_t          cmd_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [1:0]    status_reg, status_next;
    logic          done_reg;
    logic          take;
    cell_ctl_t     ctl;
    logic [AW-1:0] cell_ptr;

    logic [HDW-1:0] c_handle [POOL_ENTRIES];
    logic [7:0]     c_y      [POOL_ENTRIES];
    logic [8:0]     c_x      [POOL_ENTRIES];
    logic           c_dbl    [POOL_ENTRIES];

    assign take = start && !busy;

    // chain of order cells
    for (genvar i = 0; i < POOL_ENTRIES; i++)
    begin : g_cell
        localparam int UP = (i + 1 < POOL_ENTRIES) ? i + 1 : i;
        localparam int DN = (i > 0) ? i - 1 : 0;
        sysort_cell #(.IDX(i), .AW(AW), .HDW(HDW)) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .ptr        (cell_ptr),
            .cmd_handle (HDW'(count_reg)),
            .cmd_y      (cmd_reg.y_position),
            .cmd_x      (cmd_reg.x_position),
            .cmd_dbl    (cmd_reg.double_size),
            .up_handle  (c_handle[UP]),
            .up_y       (c_y[UP]),
            .up_x       (c_x[UP]),
            .up_dbl     (c_dbl[UP]),
            .dn_handle  (c_handle[DN]),
            .dn_y       (c_y[DN]),
            .dn_x       (c_x[DN]),
            .dn_dbl     (c_dbl[DN]),
            .handle     (c_handle[i]),
            .y          (c_y[i]),
            .x          (c_x[i]),
            .dbl        (c_dbl[i])
        );
    end

    // slot bit for each order position
    logic [7:0] mask_lut [POOL_ENTRIES];
    for (genvar i = 0; i < POOL_ENTRIES; i++)
    begin : g_mask
        assign mask_lut[i] = 8'((32'(1) << (i % HW_SLOTS)) & 32'hff);
    end

    // neighbor views around the current position
    logic [HDW-1:0] cur_handle;
    logic [7:0]     cur_y, nxt_y, prv_y;
    logic [CW-1:0]  pos_ext;
    logic           up_ok, dn_ok;
    assign cur_handle = c_handle[pos_reg];
    assign cur_y      = c_y[pos_reg];
    assign pos_ext    = CW'(pos_reg);
    assign up_ok      = (pos_ext + CW'(1) < count_reg);
    assign dn_ok      = (pos_reg != '0);
    assign nxt_y      = up_ok ? c_y[pos_reg + AW'(1)] : '0;
    assign prv_y      = dn_ok ? c_y[pos_reg - AW'(1)] : '0;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        status_next = status_reg;
        ctl         = '0;
        cell_ptr    = pos_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    pos_next = '0;
                    if (cmd.op == OP_ALLOC)
                    begin
                        if (count_reg >= CW'(POOL_ENTRIES))
                            status_next = ST_FULL;
                        else
                        begin
                            status_next = ST_OK;
                            pos_next    = AW'(count_reg);
                        end
                        state_next = S_DONE;
                    end
                    else if (cmd.op == OP_BAD || KW'(cmd.handle) >= KW'(count_reg))
                    begin
                        status_next = ST_NOHNDL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        status_next = ST_OK;
                        state_next  = S_FIND;
                    end
                end
            end
            S_FIND:
            begin
                if (cur_handle == HDW'(cmd_reg.handle))
                begin
                    if (cmd_reg.op == OP_SET_X)
                    begin
                        ctl.setx   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ctl.sety  = 1'b1;
                        if (cmd_reg.y_position == cur_y)
                            state_next = S_DONE;
                        else if (cmd_reg.y_position > cur_y)
                            state_next = S_UP;
                        else
                            state_next = S_DOWN;
                    end
                end
                else
                    pos_next = pos_reg + AW'(1);
            end
            S_UP:
            begin
                if (up_ok && cmd_reg.y_position > nxt_y)
                begin
                    ctl.swap_dn = 1'b1;
                    pos_next    = pos_reg + AW'(1);
                end
                else
                    state_next = S_DONE;
            end
            S_DOWN:
            begin
                if (dn_ok && prv_y > cmd_reg.y_position)
                begin
                    ctl.swap_dn = 1'b1;
                    cell_ptr    = pos_reg - AW'(1);
                    pos_next    = pos_reg - AW'(1);
                end
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (cmd_reg.op == OP_ALLOC && status_reg == ST_OK)
                begin
                    ctl.load   = 1'b1;
                    count_next = count_reg + CW'(1);
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= (state_reg == S_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && take)
            cmd_reg <= cmd;
        pos_reg    <= pos_next;
        status_reg <= status_next;
    end

    // result register
    result_t res_reg;
    logic    ok_set;
    assign ok_set = (status_reg == ST_OK) && (cmd_reg.op != OP_ALLOC);
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE)
        begin
            res_reg.status      <= status_reg;
            res_reg.entry_count <= 6'(count_next);
            if (status_reg == ST_FULL)
            begin
                res_reg.entry_id       <= '0;
                res_reg.order_position <= '0;
                res_reg.slot_mask      <= '0;
                res_reg.high_x         <= 1'b0;
            end
            else if (status_reg == ST_NOHNDL)
            begin
                res_reg.entry_id       <= cmd_reg.handle;
                res_reg.order_position <= '0;
                res_reg.slot_mask      <= '0;
                res_reg.high_x         <= 1'b0;
            end
            else
            begin
                res_reg.entry_id       <= (cmd_reg.op == OP_ALLOC) ?
                                          5'(count_reg) : cmd_reg.handle;
                res_reg.order_position <= 5'(pos_reg);
                res_reg.slot_mask      <= mask_lut[pos_reg];
                res_reg.high_x         <= ok_set ? c_x[pos_reg][8] : 1'b0;
            end
        end
    end

    assign busy   = (state_reg != S_IDLE) || done_reg;
    assign done   = done_reg;
    assign result = res_reg;

    // checks
    `SYS_ASSERT(a_count_range, count_reg <= CW'(POOL_ENTRIES))
    `SYS_ASSERT(a_done_busy, !done || busy)
    `SYS_ASSERT_NEXT(a_done_pulse, done, !done)
    `SYS_ASSERT_NEXT(a_take_busy, start && !busy, busy)
endmodule
